// ===== rtl/slvk_pkg.sv =====
// Shared types, codes and constants for the slew-limited vehicle kinematics block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none
package slvk_pkg;

	localparam int SLVK_TRIG_BITS = 16;
	localparam int CORDIC_LEN     = 24;
	localparam int DIV_NUM_W      = 17;
	localparam int FREQ_W         = 10;

	localparam logic [19:0] DEPTH_MAX    = 20'd1000000;
	localparam logic [14:0] SPEED_MAX    = 15'd20000;
	localparam logic [15:0] FULL_TURN    = 16'd36000;
	localparam logic [15:0] HALF_TURN    = 16'd18000;
	localparam logic [15:0] QUARTER_TURN = 16'd9000;
	localparam logic [47:0] TICK_MAX     = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_CMD   = 2'd1,
		OP_START = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_REFUSED   = 3'd1,
		ST_NAV       = 3'd2,
		ST_WENT_IDLE = 3'd3,
		ST_STARTED   = 3'd4,
		ST_IDLE_TICK = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_ACCEL   = 3'd0,
		REG_HEADING = 3'd1,
		REG_DEPTH   = 3'd2,
		REG_FREQ    = 3'd3,
		REG_MISSION = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_THRESH,
		SQ_CHECK,
		SQ_DIV_DEPTH,
		SQ_DIV_HDG,
		SQ_DIV_SPD,
		SQ_CORDIC,
		SQ_MUL_E,
		SQ_DIV_E,
		SQ_MUL_N,
		SQ_DIV_N,
		SQ_DONE
	} seq_t;

	// arctangent of 2^-i in 1/25600 degree
	function automatic logic signed [23:0] atan_units(input logic [4:0] i);
		logic signed [23:0] r;
		begin
			unique case (i)
				5'd0: r = 24'sd1152000;
				5'd1: r = 24'sd680065;
				5'd2: r = 24'sd359328;
				5'd3: r = 24'sd182400;
				5'd4: r = 24'sd91554;
				5'd5: r = 24'sd45822;
				5'd6: r = 24'sd22916;
				5'd7: r = 24'sd11459;
				5'd8: r = 24'sd5730;
				5'd9: r = 24'sd2865;
				5'd10: r = 24'sd1432;
				5'd11: r = 24'sd716;
				5'd12: r = 24'sd358;
				5'd13: r = 24'sd179;
				5'd14: r = 24'sd90;
				5'd15: r = 24'sd45;
				5'd16: r = 24'sd22;
				5'd17: r = 24'sd11;
				5'd18: r = 24'sd6;
				5'd19: r = 24'sd3;
				5'd20: r = 24'sd1;
				5'd21: r = 24'sd1;
				default: r = 24'sd0;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/slvk_ifs.sv =====
// Valid/ready channel interfaces: command in, report out, register write.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface slvk_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [19:0] target_depth;
	logic [14:0] target_speed;
	logic [15:0] target_heading;
	modport source (output valid, opcode, target_depth, target_speed, target_heading,
		input ready);
	modport sink (input valid, opcode, target_depth, target_speed, target_heading,
		output ready);
endinterface

interface slvk_rpt_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic signed [39:0] pos_east;
	logic signed [39:0] pos_north;
	logic [19:0]        cur_depth;
	logic [15:0]        cur_heading;
	logic [14:0]        cur_speed;
	modport source (output valid, status, pos_east, pos_north, cur_depth, cur_heading,
		cur_speed, input ready);
	modport sink (input valid, status, pos_east, pos_north, cur_depth, cur_heading,
		cur_speed, output ready);
endinterface

interface slvk_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [30:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/slvk_div.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on slvk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slvk_div import slvk_pkg::*; #(
	parameter int NUM_W = DIV_NUM_W,
	parameter int DEN_W = FREQ_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// shift in next dividend bit and try subtracting
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// ===== rtl/slvk_cordic.sv =====
// Rotation-mode CORDIC giving sin and cos of a compass heading, one iteration per cycle.
// Depends on slvk_pkg (arctangent table, turn constants).
`timescale 1ns / 1ps
`default_nettype none
module slvk_cordic import slvk_pkg::*; #(
	parameter int TRIG_BITS = SLVK_TRIG_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [15:0]           hdg,
	output logic                       done,
	output logic signed [TRIG_BITS+2:0] sin_o,
	output logic signed [TRIG_BITS+2:0] cos_o
);
	localparam int XW = TRIG_BITS + 3;
	localparam int NIT = (TRIG_BITS < CORDIC_LEN) ? TRIG_BITS : CORDIC_LEN;
	localparam logic [63:0] X0_WIDE =
		(64'd2608131496 + (64'd1 << (31 - TRIG_BITS))) >> (32 - TRIG_BITS);

	logic                 run_q;
	logic                 done_q;
	logic [4:0]           cnt_q;
	logic [1:0]           quad_q;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic signed [23:0]   z_q;
	logic [1:0]           quad;
	logic [15:0]          rem;
	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic signed [23:0]   at;

	// quadrant split of the heading
	always_comb begin
		if (hdg >= 16'(3 * QUARTER_TURN)) begin
			quad = 2'd3;
			rem  = hdg - 16'(3 * QUARTER_TURN);
		end else if (hdg >= HALF_TURN) begin
			quad = 2'd2;
			rem  = hdg - HALF_TURN;
		end else if (hdg >= QUARTER_TURN) begin
			quad = 2'd1;
			rem  = hdg - QUARTER_TURN;
		end else begin
			quad = 2'd0;
			rem  = hdg;
		end
		dx = y_q >>> cnt_q;
		dy = x_q >>> cnt_q;
		at = atan_units(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quad_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				cnt_q  <= '0;
				quad_q <= quad;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'(NIT - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// micro-rotation datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= X0_WIDE[XW-1:0];
			y_q <= '0;
			// remainder stays below a quarter turn, so the top bit is clear
			z_q <= $signed({rem, 8'd0});
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	// quadrant fold-back
	always_comb begin
		unique case (quad_q)
			2'd0: begin sin_o = y_q;  cos_o = x_q;  end
			2'd1: begin sin_o = x_q;  cos_o = -y_q; end
			2'd2: begin sin_o = -y_q; cos_o = -x_q; end
			default: begin sin_o = -x_q; cos_o = y_q; end
		endcase
	end

	assign done = done_q;
endmodule
`default_nettype wire

// ===== rtl/slew_limited_vehicle_kinematics.sv =====
// Slew-limited vehicle kinematics: top level with sequencer and state registers.
// Depends on slvk_pkg, slvk_ifs, slvk_div, slvk_cordic.
// Command, start and unarmed tick: report via the DONE state and the report register.
// Expiring tick: THRESH and CHECK first. Moving tick: five divider runs and the CORDIC;
// no new command is taken until the sequencer is back in IDLE. Opcode three: no report.
// Reset: asynchronous, clears vehicle and sequencer state, loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module slew_limited_vehicle_kinematics import slvk_pkg::*; #(
	parameter int TRIG_BITS = SLVK_TRIG_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	slvk_cmd_if.sink   cmd,
	slvk_rpt_if.source rpt,
	slvk_cfg_if.sink   cfg
);
	localparam int XW = TRIG_BITS + 3;
	localparam int PW = XW + 16;

	seq_t state_q, state_d;

	logic [13:0] accel_rate_q, depth_rate_q;
	logic [15:0] heading_rate_q;
	logic [9:0]  tick_frequency_q;
	logic [30:0] mission_seconds_q;

	logic signed [39:0] east_q, north_q;
	logic [19:0] depth_q, depth_goal_q;
	logic [14:0] speed_q, speed_goal_q;
	logic [15:0] heading_q, heading_goal_q;
	logic [47:0] tick_q;
	logic        active_q;
	logic [2:0]  status_q;
	logic [41:0] thr_q;
	logic signed [PW-1:0] prod_q;

	logic               out_valid_q;
	logic [2:0]         out_status_q;
	logic signed [39:0] out_east_q, out_north_q;
	logic [19:0]        out_depth_q;
	logic [15:0]        out_heading_q;
	logic [14:0]        out_speed_q;

	logic [9:0]           fe;
	logic                 div_run_q, div_start, div_done;
	logic [DIV_NUM_W-1:0] div_num, div_quo;
	logic                 cor_run_q, cor_start, cor_done;
	logic signed [XW-1:0] sin_v, cos_v;
	logic                 accept, out_free, is_div;
	logic [PW-1:0]        abs_p;
	logic signed [39:0]   delta;
	logic signed [17:0]   hd, hs, nh;

	function automatic logic [19:0] approach(input logic [19:0] now, input logic [19:0] goal,
		input logic [DIV_NUM_W-1:0] step);
		logic [19:0] st;
		begin
			st = 20'(step);
			if (now > goal)
				return ((now - goal) > st) ? now - st : goal;
			return ((goal - now) > st) ? now + st : goal;
		end
	endfunction

	assign fe        = (tick_frequency_q == '0) ? 10'd1 : tick_frequency_q;
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || rpt.ready;
	assign cmd.ready = (state_q == SQ_IDLE);
	assign cfg.ready = 1'b1;
	assign is_div    = (state_q == SQ_DIV_DEPTH) || (state_q == SQ_DIV_HDG) ||
		(state_q == SQ_DIV_SPD) || (state_q == SQ_DIV_E) || (state_q == SQ_DIV_N);
	assign div_start = is_div && !div_run_q;
	assign cor_start = (state_q == SQ_CORDIC) && !cor_run_q;

	// divider operand select and position delta
	always_comb begin
		abs_p = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
		unique case (state_q)
			SQ_DIV_DEPTH: div_num = DIV_NUM_W'(depth_rate_q);
			SQ_DIV_HDG:   div_num = DIV_NUM_W'(heading_rate_q);
			SQ_DIV_SPD:   div_num = DIV_NUM_W'(accel_rate_q);
			default:      div_num = DIV_NUM_W'(abs_p >> TRIG_BITS);
		endcase
		delta = prod_q[PW-1] ? -$signed(40'(div_quo)) : $signed(40'(div_quo));
	end

	// heading step, shorter way round
	always_comb begin
		hd = $signed({2'b00, heading_goal_q}) - $signed({2'b00, heading_q});
		if (hd <= -$signed({2'b00, HALF_TURN}))
			hd = hd + $signed({2'b00, FULL_TURN});
		else if (hd > $signed({2'b00, HALF_TURN}))
			hd = hd - $signed({2'b00, FULL_TURN});
		hs = $signed({1'b0, div_quo});
		if (hd > hs)
			hd = hs;
		else if (hd < -hs)
			hd = -hs;
		nh = $signed({2'b00, heading_q}) + hd;
		if (nh < 0)
			nh = nh + $signed({2'b00, FULL_TURN});
		else if (nh >= $signed({2'b00, FULL_TURN}))
			nh = nh - $signed({2'b00, FULL_TURN});
	end

	slvk_div #(.NUM_W(DIV_NUM_W), .DEN_W(FREQ_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(fe),
		.done(div_done), .quo(div_quo)
	);

	slvk_cordic #(.TRIG_BITS(TRIG_BITS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .hdg(heading_q),
		.done(cor_done), .sin_o(sin_v), .cos_o(cos_v)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= SQ_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					unique case (opcode_t'(cmd.opcode))
						OP_TICK:  state_d = active_q ? SQ_THRESH : SQ_DONE;
						OP_CMD:   state_d = SQ_DONE;
						OP_START: state_d = SQ_DONE;
						default:  state_d = SQ_IDLE;
					endcase
				end
			end
			SQ_THRESH: state_d = SQ_CHECK;
			SQ_CHECK: begin
				if (mission_seconds_q != '0 && tick_q >= 48'(thr_q))
					state_d = SQ_DONE;
				else
					state_d = SQ_DIV_DEPTH;
			end
			SQ_DIV_DEPTH: if (div_done && div_run_q) state_d = SQ_DIV_HDG;
			SQ_DIV_HDG:   if (div_done && div_run_q) state_d = SQ_DIV_SPD;
			SQ_DIV_SPD:   if (div_done && div_run_q) state_d = SQ_CORDIC;
			SQ_CORDIC:    if (cor_done && cor_run_q) state_d = SQ_MUL_E;
			SQ_MUL_E:     state_d = SQ_DIV_E;
			SQ_DIV_E:     if (div_done && div_run_q) state_d = SQ_MUL_N;
			SQ_MUL_N:     state_d = SQ_DIV_N;
			SQ_DIV_N:     if (div_done && div_run_q) state_d = SQ_DONE;
			SQ_DONE:      if (out_free) state_d = SQ_IDLE;
			default:      state_d = SQ_IDLE;
		endcase
	end

	// unit handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q <= 1'b0;
			cor_run_q <= 1'b0;
		end else begin
			if (div_start)
				div_run_q <= 1'b1;
			else if (div_done)
				div_run_q <= 1'b0;
			if (cor_start)
				cor_run_q <= 1'b1;
			else if (cor_done)
				cor_run_q <= 1'b0;
		end
	end

	// registers and vehicle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_rate_q      <= 14'd500;
			heading_rate_q    <= 16'd4500;
			depth_rate_q      <= 14'd2000;
			tick_frequency_q  <= 10'd10;
			mission_seconds_q <= '0;
			east_q         <= '0;
			north_q        <= '0;
			depth_q        <= '0;
			speed_q        <= '0;
			heading_q      <= '0;
			depth_goal_q   <= '0;
			speed_goal_q   <= '0;
			heading_goal_q <= '0;
			tick_q         <= '0;
			active_q       <= 1'b0;
			status_q       <= ST_ACCEPTED;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_ACCEL:   accel_rate_q      <= cfg.data[13:0];
					REG_HEADING: heading_rate_q    <= cfg.data[15:0];
					REG_DEPTH:   depth_rate_q      <= cfg.data[13:0];
					REG_FREQ:    tick_frequency_q  <= cfg.data[9:0];
					REG_MISSION: mission_seconds_q <= cfg.data;
					default: ;
				endcase
			end

			// report valid: set on leaving DONE, cleared when the beat is taken
			if (state_q == SQ_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (rpt.valid && rpt.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				SQ_IDLE: begin
					if (accept) begin
						unique case (opcode_t'(cmd.opcode))
							OP_TICK: begin
								if (tick_q != TICK_MAX)
									tick_q <= tick_q + 1'b1;
								status_q <= ST_IDLE_TICK;
							end
							OP_CMD: begin
								if (active_q) begin
									depth_goal_q <= (cmd.target_depth > DEPTH_MAX) ?
										DEPTH_MAX : cmd.target_depth;
									speed_goal_q <= (cmd.target_speed > SPEED_MAX) ?
										SPEED_MAX : cmd.target_speed;
									heading_goal_q <= (cmd.target_heading >= FULL_TURN) ?
										cmd.target_heading - FULL_TURN : cmd.target_heading;
									status_q <= ST_ACCEPTED;
								end else begin
									status_q <= ST_REFUSED;
								end
							end
							OP_START: begin
								active_q <= 1'b1;
								tick_q   <= '0;
								status_q <= ST_STARTED;
							end
							default: ;
						endcase
					end
				end
				SQ_CHECK: begin
					if (mission_seconds_q != '0 && tick_q >= 48'(thr_q)) begin
						active_q <= 1'b0;
						status_q <= ST_WENT_IDLE;
					end else begin
						status_q <= ST_NAV;
					end
				end
				SQ_DIV_DEPTH: if (div_done && div_run_q)
					depth_q <= approach(depth_q, depth_goal_q, div_quo);
				SQ_DIV_HDG: if (div_done && div_run_q)
					heading_q <= nh[15:0];
				SQ_DIV_SPD: if (div_done && div_run_q)
					speed_q <= 15'(approach(20'(speed_q), 20'(speed_goal_q), div_quo));
				SQ_DIV_E: if (div_done && div_run_q)
					east_q <= east_q + delta;
				SQ_DIV_N: if (div_done && div_run_q)
					north_q <= north_q + delta;
				default: ;
			endcase
		end
	end

	// threshold, products and report payload
	always_ff @(posedge clk) begin
		// (mission_seconds + 1) * f, full width
		if (state_q == SQ_THRESH)
			thr_q <= 42'(mission_seconds_q) * 42'(fe) + 42'(fe);
		if (state_q == SQ_MUL_E)
			prod_q <= PW'($signed({1'b0, speed_q}) * sin_v);
		if (state_q == SQ_MUL_N)
			prod_q <= PW'($signed({1'b0, speed_q}) * cos_v);
		if (state_q == SQ_DONE && out_free) begin
			out_status_q  <= status_q;
			out_east_q    <= east_q;
			out_north_q   <= north_q;
			out_depth_q   <= depth_q;
			out_heading_q <= heading_q;
			out_speed_q   <= speed_q;
		end
	end

	assign rpt.valid       = out_valid_q;
	assign rpt.status      = out_status_q;
	assign rpt.pos_east    = out_east_q;
	assign rpt.pos_north   = out_north_q;
	assign rpt.cur_depth   = out_depth_q;
	assign rpt.cur_heading = out_heading_q;
	assign rpt.cur_speed   = out_speed_q;
endmodule
`default_nettype wire
